### sv/lru_page_cache_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the LRU page cache
// ---------------------------------------------------------------------------
`ifndef LRU_PAGE_CACHE_TOP_MACROS_SVH
`define LRU_PAGE_CACHE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/lpc_pkg.sv
// ---------------------------------------------------------------------------
// LRU page cache package
// Widths and capacity shared by the cache files.
// ---------------------------------------------------------------------------
`default_nettype none
package lpc_pkg;
  localparam int Capacity  = 16;
  localparam int PageCount = 1024;
  localparam int PageW     = 10;
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int IdxW      = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int PmapW     = $clog2(PageCount);
  localparam int SizeW     = 5;
  localparam logic [0:0] RegCacheSize = 1'b0;
endpackage
`default_nettype wire

### sv/lpc_resident_map.sv
// ---------------------------------------------------------------------------
// Residency map
// One bit per page in a synchronous memory, cleared by a sweep.
// ---------------------------------------------------------------------------
`default_nettype none
module lpc_resident_map import lpc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clr_start,
  output logic                  clr_busy,
  input  wire logic [PmapW-1:0] rd_addr,
  output logic                  rd_data,
  input  wire logic             wr_en,
  input  wire logic [PmapW-1:0] wr_addr,
  input  wire logic             wr_data
);
  logic             mem [PageCount];
  logic [PmapW-1:0] clr_ptr_r;
  logic             clr_busy_r;

  // sweep the map one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_ptr_r  <= '0;
    end else if (clr_start) begin
      clr_busy_r <= 1'b1;
      clr_ptr_r  <= '0;
    end else if (clr_busy_r) begin
      clr_ptr_r <= clr_ptr_r + 1'b1;
      if (clr_ptr_r == PmapW'(PageCount - 1)) clr_busy_r <= 1'b0;
    end
  end

  // memory port: clear has priority over writes
  always_ff @(posedge clk) begin
    if (clr_busy_r) mem[clr_ptr_r] <= 1'b0;
    else if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign clr_busy = clr_busy_r;
endmodule
`default_nettype wire

### sv/lpc_list_engine.sv
// ---------------------------------------------------------------------------
// Recency list engine
// Holds the recency list, searches it one entry a cycle and reorders it.
// ---------------------------------------------------------------------------
`default_nettype none
module lpc_list_engine import lpc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             flush,
  input  wire logic [SizeW-1:0] cache_size,
  input  wire logic             start,
  input  wire logic [PageW-1:0] page,
  input  wire logic             resident,
  output logic                  done,
  output logic                  hit,
  output logic                  ev_valid,
  output logic [PageW-1:0]      ev_page,
  output logic [CntW-1:0]       count
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT} state_t;
  state_t                state_r;
  logic [PageW-1:0]      list_r [Capacity];
  logic [CntW-1:0]       count_r;
  logic [IdxW-1:0]       pos_r;
  logic [CntW-1:0]       lim;
  logic                  done_r, hit_r, evv_r;
  logic [PageW-1:0]      evp_r, page_r;

  // effective size clamped to one..capacity
  always_comb begin
    if (cache_size == '0) lim = CntW'(1);
    else if (32'(cache_size) > Capacity) lim = CntW'(Capacity);
    else lim = CntW'(cache_size);
  end

  // list shift line: entries below pos move one place toward the tail
  always_ff @(posedge clk) begin
    if (state_r == S_SHIFT) begin
      for (int i = Capacity - 1; i > 0; i--) begin
        if (IdxW'(i) <= pos_r) list_r[i] <= list_r[i-1];
      end
      list_r[0] <= page_r;
    end
  end

  // search / insert sequencer
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      state_r <= S_IDLE;
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          page_r  <= page;
          pos_r   <= '0;
          hit_r   <= 1'b0;
          evv_r   <= 1'b0;
          evp_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (resident && 32'(pos_r) < 32'(count_r) && list_r[pos_r] == page_r) begin
            hit_r   <= 1'b1;
            state_r <= S_SHIFT;
          end else if (resident && 32'(pos_r) + 1 < 32'(count_r)) begin
            pos_r <= pos_r + 1'b1;
          end else begin
            // miss: evict tail if full, then insert
            if (count_r >= lim) begin
              evv_r   <= 1'b1;
              evp_r   <= list_r[IdxW'(count_r - 1'b1)];
              pos_r   <= IdxW'(count_r - 1'b1);
              count_r <= count_r;
            end else begin
              pos_r   <= IdxW'(count_r);
              count_r <= count_r + 1'b1;
            end
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign hit      = hit_r;
  assign ev_valid = evv_r;
  assign ev_page  = evp_r;
  assign count    = count_r;
endmodule
`default_nettype wire

### sv/lru_page_cache_top.sv
// ---------------------------------------------------------------------------
// LRU page cache top level
// Recency list with a page residency map and stream/APB ports.
// ---------------------------------------------------------------------------
// channel | dir | word
// in_     | in  | tdata[9:0] page
// out_    | out | tdata[0] hit, [1] evicted_valid, [11:2] evicted_page
// cfg_    | in  | APB, reg 0 cache_size at 0x0
// Each item goes through the map lookup, the list search over the entries
// passed over on a resident page, and the list shift; an evicted page adds a
// map clear. The result word is registered when the list engine is done, and
// a new item is accepted only after the referenced page is set in the map.
// After reset or a cache_size write the map sweep runs and no items are taken.
// A waiting result holds the next item until taken.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lru_page_cache_top_macros.svh"
module lru_page_cache_top import lpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // page[9:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // hit, evicted_valid, evicted_page[11:2]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [0:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  typedef enum logic [2:0] {T_IDLE, T_LOOK, T_RUN, T_OUT} tstate_t;
  tstate_t          st_r;
  logic [SizeW-1:0] size_r;
  logic             cfg_wr;
  logic             clr_busy, rd_res, map_we, map_wd;
  logic [PmapW-1:0] map_wa;
  logic [PageW-1:0] page_r;
  logic             start, done, hit, evv;
  logic [PageW-1:0] evp;
  logic [CntW-1:0]  count;
  logic             outv_r;
  logic [11:0]      outd_r;
  logic             ev_clr_r;
  logic [PageW-1:0] evp_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr == RegCacheSize);
  assign cfg_prdata = {27'd0, size_r};

  // hold configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= SizeW'(16);
    else if (cfg_wr) size_r <= cfg_pwdata[SizeW-1:0];
  end

  lpc_resident_map u_map (
    .clk, .rst_n, .clr_start(cfg_wr), .clr_busy,
    .rd_addr(page_r[PmapW-1:0]), .rd_data(rd_res),
    .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd)
  );

  assign start = (st_r == T_LOOK);
  lpc_list_engine u_list (
    .clk, .rst_n, .flush(cfg_wr), .cache_size(size_r),
    .start, .page(page_r), .resident(rd_res), .done, .hit,
    .ev_valid(evv), .ev_page(evp), .count
  );

  // map writes: clear evicted page, then set referenced page
  always_comb begin
    map_we = 1'b0; map_wa = page_r[PmapW-1:0]; map_wd = 1'b1;
    if (ev_clr_r) begin
      map_we = 1'b1; map_wa = evp_r[PmapW-1:0]; map_wd = 1'b0;
    end else if (st_r == T_OUT) begin
      map_we = 1'b1;
    end
  end

  assign in_tready = (st_r == T_IDLE) && !clr_busy && !outv_r;

  // sequence one reference
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      st_r <= T_IDLE; outv_r <= 1'b0; ev_clr_r <= 1'b0;
    end else begin
      ev_clr_r <= 1'b0;
      if (outv_r && out_tready) outv_r <= 1'b0;
      unique case (st_r)
        T_IDLE: if (in_tvalid && in_tready) begin
          page_r <= in_tdata[PageW-1:0];
          st_r   <= T_LOOK;
        end
        T_LOOK: st_r <= T_RUN;
        T_RUN: if (done) begin
          outv_r   <= 1'b1;
          outd_r   <= {(evv ? evp : PageW'(0)), evv, hit};
          evp_r    <= evp;
          ev_clr_r <= evv;
          st_r     <= T_OUT;
        end
        T_OUT: if (!ev_clr_r) st_r <= T_IDLE;
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = {4'd0, outd_r};

  `LPC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, clr_busy, !in_tready)
  `LPC_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, 32'(count) <= Capacity)
  `LPC_ASSERT_NXT(a_done_out, clk, rst_n, done && !cfg_wr, out_tvalid)
endmodule
`default_nettype wire
